/* rtl/core/tbo_pkg.sv */
// ============================================================================
// tbo_pkg
// Shared widths, types, register indexes and lane helpers for the
// triangle/box overlap test core.
// ============================================================================
package tbo_pkg;

   // Component width of one packed coordinate (signed Q8.8 at 16 bits)
   localparam int COORD_BITS = 16;

   // Fixed widths of the item fields and the size registers
   localparam int FIELD_W = 48;
   localparam int SIZE_W  = 15;
   localparam int CSR_IDX_W = 2;

   // Derived datapath widths
   localparam int VEC_W  = COORD_BITS + 1;           // vertex minus center
   localparam int EDGE_W = COORD_BITS + 2;           // vertex difference
   localparam int MAG_W  = COORD_BITS + 1;           // |edge component|
   localparam int EP_W   = EDGE_W + VEC_W;           // edge x vertex product
   localparam int ER_W   = MAG_W + SIZE_W;           // |edge| x size product
   localparam int NP_W   = COORD_BITS + VEC_W;       // normal x vertex product
   localparam int NR_W   = COORD_BITS + SIZE_W;      // |normal| x size product
   localparam int CMP_W  = (2 * COORD_BITS + 6 > COORD_BITS + 19) ?
                           2 * COORD_BITS + 6 : COORD_BITS + 19;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] BOX_SIZE_RESET = 15'd256;

   typedef logic [FIELD_W-1:0]           field_type;
   typedef logic [SIZE_W-1:0]            size_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [VEC_W-1:0]      vec_type;
   typedef logic signed [EDGE_W-1:0]     edge_type;
   typedef logic [MAG_W-1:0]             mag_type;
   typedef logic [COORD_BITS-1:0]        nmag_type;
   typedef logic signed [EP_W-1:0]       eprod_type;
   typedef logic [ER_W-1:0]              erad_type;
   typedef logic signed [NP_W-1:0]       nprod_type;
   typedef logic [NR_W-1:0]              nrad_type;
   typedef logic signed [CMP_W-1:0]      cmp_type;

   // Extract component k of a packed word; lanes past the field read as zero
   function automatic coord_type get_lane(input field_type word, input int k);
      logic [3*COORD_BITS-1:0] ext;
      ext = (3*COORD_BITS)'(word);
      return coord_type'(ext[k*COORD_BITS +: COORD_BITS]);
   endfunction

   // Next index modulo three
   function automatic int next3(input int k);
      return (k == 2) ? 0 : k + 1;
   endfunction

endpackage

/* rtl/core/triangle_box_overlap_test_core.sv */
// ============================================================================
// triangle_box_overlap_test_core
// The overlap word is on the result ports together with rsp_strobe,
// registered by the result stage.
// Throughput: one test per cycle; busy stays low, the receiver cannot stall.
// Five register stages (input, difference, product, sum, result) set the
// latency; each holds one word, so a new word can enter every cycle.
// Reset clears all valid bits and loads each box size with 1.0 (256).
// ============================================================================
module triangle_box_overlap_test_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tbo_pkg::FIELD_W-1:0] req_box_center,
   input  logic [tbo_pkg::FIELD_W-1:0] req_vertex_a,
   input  logic [tbo_pkg::FIELD_W-1:0] req_vertex_b,
   input  logic [tbo_pkg::FIELD_W-1:0] req_vertex_c,
   input  logic [tbo_pkg::FIELD_W-1:0] req_face_normal,
   output logic                        rsp_strobe,
   output logic                        rsp_overlaps,
   input  logic                          csr_write_en,
   input  logic [tbo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbo_pkg::SIZE_W-1:0]    csr_wdata
);
   import tbo_pkg::*;

   // --------------------------------------------------------------- control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_strobe_ff;
   logic accept;

   size_type size_ff [3];

   // Stage 1: captured word
   field_type center_ff, normal_ff;
   field_type vert_ff [3];

   // Stage 2: relative vertices, edges, magnitudes
   vec_type  v_in     [3][3];
   vec_type  v_ff     [3][3];
   edge_type e_in     [3][3];
   edge_type e_ff     [3][3];
   edge_type e_abs    [3][3];
   mag_type  emag_in  [3][3];
   mag_type  emag_ff  [3][3];
   coord_type n_in    [3];
   coord_type n_ff    [3];
   logic signed [COORD_BITS:0] n_ext [3];
   logic signed [COORD_BITS:0] n_abs [3];
   nmag_type nmag_in  [3];
   nmag_type nmag_ff  [3];

   // Stage 3: products and box-axis verdicts
   eprod_type ep_in [3][3][2][2];
   eprod_type ep_ff [3][3][2][2];
   erad_type  er_in [3][3][2];
   erad_type  er_ff [3][3][2];
   nprod_type np_in [3][3];
   nprod_type np_ff [3][3];
   nrad_type  nr_in [3];
   nrad_type  nr_ff [3];
   logic      sep_box_in, sep_box_s3_ff;
   cmp_type   box_dv [3];
   cmp_type   box_r;
   logic      box_all_hi, box_all_lo;

   // Stage 4: projections and radii
   cmp_type pe_in [3][3][2];
   cmp_type pe_ff [3][3][2];
   cmp_type re_in [3][3];
   cmp_type re_ff [3][3];
   cmp_type pn_in [3];
   cmp_type pn_ff [3];
   cmp_type rn_in;
   cmp_type rn_ff;
   logic    sep_box_s4_ff;

   // Result
   logic    sep_any;
   logic    overlaps_in, rsp_overlaps_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Advance valid bits and hold the size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         size_ff[0]    <= BOX_SIZE_RESET;
         size_ff[1]    <= BOX_SIZE_RESET;
         size_ff[2]    <= BOX_SIZE_RESET;
      end else begin
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         rsp_strobe_ff <= s4_valid_ff;
         if (csr_write_en) begin
            case (csr_index)
               CSR_BOX_SIZE_X: size_ff[0] <= csr_wdata;
               CSR_BOX_SIZE_Y: size_ff[1] <= csr_wdata;
               CSR_BOX_SIZE_Z: size_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (accept) begin
         center_ff  <= req_box_center;
         vert_ff[0] <= req_vertex_a;
         vert_ff[1] <= req_vertex_b;
         vert_ff[2] <= req_vertex_c;
         normal_ff  <= req_face_normal;
      end
   end

   // Move vertices to the box frame, form edges and magnitudes
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            v_in[j][k] = VEC_W'(get_lane(vert_ff[j], k)) - VEC_W'(get_lane(center_ff, k));
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            e_in[i][k]    = EDGE_W'(v_in[next3(i)][k]) - EDGE_W'(v_in[i][k]);
            e_abs[i][k]   = e_in[i][k][EDGE_W-1] ? -e_in[i][k] : e_in[i][k];
            emag_in[i][k] = e_abs[i][k][MAG_W-1:0];
         end
      end
      for (int k = 0; k < 3; k++) begin
         n_in[k]    = get_lane(normal_ff, k);
         n_ext[k]   = (COORD_BITS+1)'(n_in[k]);
         n_abs[k]   = n_ext[k][COORD_BITS] ? -n_ext[k] : n_ext[k];
         nmag_in[k] = n_abs[k][COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      e_ff    <= e_in;
      emag_ff <= emag_in;
      n_ff    <= n_in;
      nmag_ff <= nmag_in;
   end

   // Multiply: edge-cross axes use two vertices, since the edge's own two
   // endpoints project to the same value
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            for (int s = 0; s < 2; s++) begin
               ep_in[i][k][s][0] = EP_W'(e_ff[i][next3(next3(k))]) *
                                   EP_W'(v_ff[(s == 0) ? i : next3(next3(i))][next3(k)]);
               ep_in[i][k][s][1] = EP_W'(e_ff[i][next3(k)]) *
                                   EP_W'(v_ff[(s == 0) ? i : next3(next3(i))][next3(next3(k))]);
            end
            er_in[i][k][0] = ER_W'(emag_ff[i][next3(next3(k))]) * ER_W'(size_ff[next3(k)]);
            er_in[i][k][1] = ER_W'(emag_ff[i][next3(k)]) * ER_W'(size_ff[next3(next3(k))]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            np_in[j][k] = NP_W'(n_ff[k]) * NP_W'(v_ff[j][k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         nr_in[k] = NR_W'(nmag_ff[k]) * NR_W'(size_ff[k]);
      end
   end

   // Test the three box axes directly
   always_comb begin
      sep_box_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         box_r      = CMP_W'(size_ff[k]);
         box_all_hi = 1'b1;
         box_all_lo = 1'b1;
         for (int j = 0; j < 3; j++) begin
            box_dv[j]  = CMP_W'(v_ff[j][k]) + CMP_W'(v_ff[j][k]);
            box_all_hi = box_all_hi & (box_dv[j] > box_r);
            box_all_lo = box_all_lo & (box_dv[j] < -box_r);
         end
         sep_box_in = sep_box_in | box_all_hi | box_all_lo;
      end
   end

   always_ff @(posedge clock) begin
      ep_ff         <= ep_in;
      er_ff         <= er_in;
      np_ff         <= np_in;
      nr_ff         <= nr_in;
      sep_box_s3_ff <= sep_box_in;
   end

   // Sum products into doubled projections and full-size radii
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            for (int s = 0; s < 2; s++) begin
               pe_in[i][k][s] = (CMP_W'(ep_ff[i][k][s][1]) - CMP_W'(ep_ff[i][k][s][0])) <<< 1;
            end
            re_in[i][k] = CMP_W'(er_ff[i][k][0]) + CMP_W'(er_ff[i][k][1]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         pn_in[j] = (CMP_W'(np_ff[j][0]) + CMP_W'(np_ff[j][1]) + CMP_W'(np_ff[j][2])) <<< 1;
      end
      rn_in = CMP_W'(nr_ff[0]) + CMP_W'(nr_ff[1]) + CMP_W'(nr_ff[2]);
   end

   always_ff @(posedge clock) begin
      pe_ff         <= pe_in;
      re_ff         <= re_in;
      pn_ff         <= pn_in;
      rn_ff         <= rn_in;
      sep_box_s4_ff <= sep_box_s3_ff;
   end

   // Separate when every projection lies strictly beyond the same side
   always_comb begin
      sep_any = sep_box_s4_ff;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            sep_any = sep_any |
                      ((pe_ff[i][k][0] > re_ff[i][k]) & (pe_ff[i][k][1] > re_ff[i][k])) |
                      ((pe_ff[i][k][0] < -re_ff[i][k]) & (pe_ff[i][k][1] < -re_ff[i][k]));
         end
      end
      sep_any = sep_any |
                ((pn_ff[0] > rn_ff) & (pn_ff[1] > rn_ff) & (pn_ff[2] > rn_ff)) |
                ((pn_ff[0] < -rn_ff) & (pn_ff[1] < -rn_ff) & (pn_ff[2] < -rn_ff));
      overlaps_in = ~sep_any;
   end

   always_ff @(posedge clock) begin
      rsp_overlaps_ff <= overlaps_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_overlaps = rsp_overlaps_ff;

endmodule

/* rtl/core/tbo_checker.sv */
// ============================================================================
// tbo_checker
// Port-level checks on latency, result pairing and a degenerate case.
// ============================================================================
module tbo_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [tbo_pkg::FIELD_W-1:0]   req_box_center,
   input  logic [tbo_pkg::FIELD_W-1:0]   req_vertex_a,
   input  logic [tbo_pkg::FIELD_W-1:0]   req_vertex_b,
   input  logic [tbo_pkg::FIELD_W-1:0]   req_vertex_c,
   input  logic [tbo_pkg::FIELD_W-1:0]   req_face_normal,
   input  logic                          rsp_strobe,
   input  logic                          rsp_overlaps
);
   import tbo_pkg::*;

   // Never refuse a word
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("core raised busy");

   // Every accepted word yields a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("result missing five cycles after start");

   // No result without a matching accepted word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 5))
      else $error("result without matching start");

   // A triangle collapsed onto the box center always overlaps
   a_point_at_center: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_vertex_a == req_box_center &&
       req_vertex_b == req_box_center && req_vertex_c == req_box_center &&
       req_face_normal == '0) |-> ##5 rsp_overlaps)
      else $error("point at box center reported as separated");

endmodule

bind triangle_box_overlap_test_core tbo_checker u_tbo_checker (.*);
